/* rtl/core/mprf_pkg.sv */
`timescale 1ns / 1ps

package mprf_pkg;

  // Shortest packet that still carries a whole header
  localparam int unsigned HEADER_BYTES = 10;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    VERDICT_SHORT     = 3'd0,
    VERDICT_OTHER_NET = 3'd1,
    VERDICT_OWN_ECHO  = 3'd2,
    VERDICT_AUTH_FAIL = 3'd3,
    VERDICT_DUPLICATE = 3'd4,
    VERDICT_ACCEPTED  = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    HELLO_NONE  = 2'd0,
    HELLO_PLAIN = 2'd1,
    HELLO_ASK   = 2'd2
  } hello_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_NETWORK  = 3'd0,
    CFG_OWN_ID       = 3'd1,
    CFG_BROADCAST_ID = 3'd2,
    CFG_CIPHER_ON    = 3'd3,
    CFG_HELLO_TYPE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_END,
    ST_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the request header
    logic scan_start;  // clear scan index and match flags
    logic scan_step;   // read one ring entry and one peer slot, advance
    logic emit_early;  // register a result for a header-check drop
    logic emit_final;  // register the final result and commit state
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic early_drop;  // header checks reject the request
    logic scan_last;   // scan index is on its last position
  } dp_status_t;

endpackage

/* rtl/core/mprf_ctrl.sv */
`timescale 1ns / 1ps

module mprf_ctrl import mprf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = status.early_drop ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.emit_early = status.early_drop;
        cmd.scan_start = !status.early_drop;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_SCAN_END: begin
        cmd = '0;
      end
      ST_COMMIT: begin
        cmd.emit_final = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/mprf_datapath.sv */
`timescale 1ns / 1ps

module mprf_datapath import mprf_pkg::*; #(
  parameter int unsigned SEEN_DEPTH = 32,
  parameter int unsigned PEER_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            in_packet_len,
  input  logic [7:0]            in_packet_type,
  input  logic [7:0]            in_flag_byte,
  input  logic [7:0]            in_network_id,
  input  logic [15:0]           in_source_id,
  input  logic [15:0]           in_dest_id,
  input  logic [15:0]           in_seq_number,
  input  logic [7:0]            in_ttl_byte,
  input  logic                  in_auth_ok,
  output logic                  out_valid,
  output logic [2:0]            out_verdict,
  output logic                  out_deliver,
  output logic                  out_relay,
  output logic [7:0]            out_relay_ttl_byte,
  output logic                  out_peer_known,
  output logic [2:0]            out_peer_slot,
  output logic                  out_peer_added,
  output logic                  out_peer_direct,
  output logic [1:0]            out_hello_request
);

  localparam int unsigned SCAN_LEN = (SEEN_DEPTH > PEER_SLOTS) ? SEEN_DEPTH : PEER_SLOTS;
  localparam int unsigned IW   = $clog2(SCAN_LEN);
  localparam int unsigned SIW  = $clog2(SEEN_DEPTH);
  localparam int unsigned PIW  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CW   = $clog2(PEER_SLOTS + 1);
  localparam int unsigned CMPW = (IW > CW) ? IW : CW;

  // Configuration registers
  logic [7:0]  own_network_r;
  logic [15:0] own_id_r;
  logic [15:0] broadcast_id_r;
  logic        cipher_on_r;
  logic [7:0]  hello_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_network_r  <= 8'd0;
      own_id_r       <= 16'd1;
      broadcast_id_r <= 16'hFFFF;
      cipher_on_r    <= 1'b0;
      hello_type_r   <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_NETWORK:  own_network_r  <= cfg_data[7:0];
        CFG_OWN_ID:       own_id_r       <= cfg_data;
        CFG_BROADCAST_ID: broadcast_id_r <= cfg_data;
        CFG_CIPHER_ON:    cipher_on_r    <= cfg_data[0];
        CFG_HELLO_TYPE:   hello_type_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Captured header
  logic [7:0]  len_r, ptype_r, flags_r, net_r, ttl_r;
  logic [15:0] src_r, dst_r, seq_r;
  logic        auth_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r   <= in_packet_len;
      ptype_r <= in_packet_type;
      flags_r <= in_flag_byte;
      net_r   <= in_network_id;
      src_r   <= in_source_id;
      dst_r   <= in_dest_id;
      seq_r   <= in_seq_number;
      ttl_r   <= in_ttl_byte;
      auth_r  <= in_auth_ok;
    end
  end

  logic [31:0] key;
  assign key = {src_r, seq_r};

  // Header checks in priority order
  verdict_t early_verdict;
  always_comb begin
    if (len_r < 8'(HEADER_BYTES))                  early_verdict = VERDICT_SHORT;
    else if (net_r != own_network_r)               early_verdict = VERDICT_OTHER_NET;
    else if (src_r == own_id_r)                    early_verdict = VERDICT_OWN_ECHO;
    else if (cipher_on_r && (!flags_r[0] || !auth_r)) early_verdict = VERDICT_AUTH_FAIL;
    else                                           early_verdict = VERDICT_ACCEPTED;
  end

  // Ring and peer table state
  logic [31:0]    seen_mem [SEEN_DEPTH];
  logic [15:0]    peer_mem [PEER_SLOTS];
  logic [SIW-1:0] seen_ptr_r;
  logic           seen_full_r;
  logic [CW-1:0]  peer_count_r;

  // Scan
  logic [IW-1:0]  idx_r;
  logic           pend_r, seen_ok_r, seen_zero_r, peer_ok_r, hit_r, found_r;
  logic [PIW-1:0] peer_idx_r, slot_r;
  logic [31:0]    seen_rd_r;
  logic [15:0]    peer_rd_r;
  logic           seen_ok, seen_zero, peer_ok;

  // Ring slots at and past the write pointer are unwritten until the first wrap
  // and stand for zero keys
  assign seen_ok   = (seen_full_r && ({1'b0, idx_r} < (IW+1)'(SEEN_DEPTH)))
                     || (idx_r < IW'(seen_ptr_r));
  assign seen_zero = !seen_full_r && ({1'b0, idx_r} < (IW+1)'(SEEN_DEPTH))
                     && (idx_r >= IW'(seen_ptr_r));
  assign peer_ok = CMPW'(idx_r) < CMPW'(peer_count_r);

  assign status.early_drop = (early_verdict != VERDICT_ACCEPTED);
  assign status.scan_last  = (idx_r == IW'(SCAN_LEN - 1));

  logic           commit, peer_room, add_peer;
  logic [PIW-1:0] slot_sel;

  assign commit    = cmd.emit_final && !hit_r;
  assign peer_room = peer_count_r < CW'(PEER_SLOTS);
  assign add_peer  = !found_r && peer_room;
  assign slot_sel  = add_peer ? peer_count_r[PIW-1:0] : slot_r;

  always_ff @(posedge clk) begin
    if (commit) seen_mem[seen_ptr_r] <= key;
    if (commit && add_peer) peer_mem[peer_count_r[PIW-1:0]] <= src_r;
    seen_rd_r   <= seen_mem[idx_r[SIW-1:0]];
    peer_rd_r   <= peer_mem[idx_r[PIW-1:0]];
    seen_ok_r   <= seen_ok;
    seen_zero_r <= seen_zero;
    peer_ok_r   <= peer_ok;
    peer_idx_r  <= idx_r[PIW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ptr_r   <= '0;
      seen_full_r  <= 1'b0;
      peer_count_r <= '0;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      hit_r        <= 1'b0;
      found_r      <= 1'b0;
      slot_r       <= '0;
    end else begin
      pend_r <= cmd.scan_step;
      if (cmd.scan_start) begin
        idx_r   <= '0;
        hit_r   <= 1'b0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_step) idx_r <= idx_r + 1'b1;
        if (pend_r) begin
          if ((seen_ok_r && (seen_rd_r == key)) || (seen_zero_r && (key == 32'd0)))
            hit_r <= 1'b1;
          if (peer_ok_r && (peer_rd_r == src_r) && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= peer_idx_r;
          end
        end
      end
      if (commit) begin
        if (seen_ptr_r == SIW'(SEEN_DEPTH - 1)) begin
          seen_ptr_r  <= '0;
          seen_full_r <= 1'b1;
        end else begin
          seen_ptr_r <= seen_ptr_r + 1'b1;
        end
        if (add_peer) peer_count_r <= peer_count_r + 1'b1;
      end
    end
  end

  // Result registers
  logic       out_valid_r;
  logic [2:0] verdict_r;
  logic       deliver_r, relay_r, known_r, added_r, direct_r;
  logic [7:0] relay_ttl_r;
  logic [2:0] peer_slot_r;
  logic [1:0] hello_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_early || cmd.emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_early || (cmd.emit_final && hit_r)) begin
      verdict_r   <= cmd.emit_early ? early_verdict : VERDICT_DUPLICATE;
      deliver_r   <= 1'b0;
      relay_r     <= 1'b0;
      relay_ttl_r <= 8'd0;
      known_r     <= 1'b0;
      peer_slot_r <= 3'd0;
      added_r     <= 1'b0;
      direct_r    <= 1'b0;
      hello_r     <= HELLO_NONE;
    end else if (commit) begin
      verdict_r   <= VERDICT_ACCEPTED;
      deliver_r   <= (dst_r == own_id_r) || (dst_r == broadcast_id_r);
      relay_r     <= (dst_r != own_id_r) && (ttl_r[6:0] != 7'd0);
      relay_ttl_r <= ((dst_r != own_id_r) && (ttl_r[6:0] != 7'd0))
                     ? {1'b1, ttl_r[6:0] - 7'd1} : 8'd0;
      known_r     <= found_r || add_peer;
      peer_slot_r <= (found_r || add_peer) ? 3'(slot_sel) : 3'd0;
      added_r     <= add_peer;
      direct_r    <= !ttl_r[7];
      hello_r     <= !add_peer ? HELLO_NONE
                     : ((ptype_r != hello_type_r) ? HELLO_ASK : HELLO_PLAIN);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_deliver        = deliver_r;
  assign out_relay          = relay_r;
  assign out_relay_ttl_byte = relay_ttl_r;
  assign out_peer_known     = known_r;
  assign out_peer_slot      = peer_slot_r;
  assign out_peer_added     = added_r;
  assign out_peer_direct    = direct_r;
  assign out_hello_request  = hello_r;

endmodule

/* rtl/core/mesh_packet_rx_filter.sv */
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// input     start / busy             in_packet_len .. in_auth_ok (one header request)
// result    out_valid strobe         out_verdict .. out_hello_request
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A request is taken when start is high and busy is low.
// A request dropped by the header checks has its result registered in the header
// check state; any other request walks the duplicate ring and peer table one entry a
// cycle, then passes the scan end and commit states before its result shows. The
// next request may be taken in the cycle the result shows. Results cannot be
// stalled; out_valid is high for exactly one cycle.
// Synchronous reset empties the peer table and restarts the ring fill mark; ring
// slots not yet written since reset count as zero keys, so no clearing pass is
// needed. cfg_ready is always high.

module mesh_packet_rx_filter import mprf_pkg::*; #(
  parameter int unsigned SEEN_DEPTH = 32,
  parameter int unsigned PEER_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            in_packet_len,
  input  logic [7:0]            in_packet_type,
  input  logic [7:0]            in_flag_byte,
  input  logic [7:0]            in_network_id,
  input  logic [15:0]           in_source_id,
  input  logic [15:0]           in_dest_id,
  input  logic [15:0]           in_seq_number,
  input  logic [7:0]            in_ttl_byte,
  input  logic                  in_auth_ok,
  // result channel
  output logic                  out_valid,
  output logic [2:0]            out_verdict,
  output logic                  out_deliver,
  output logic                  out_relay,
  output logic [7:0]            out_relay_ttl_byte,
  output logic                  out_peer_known,
  output logic [2:0]            out_peer_slot,
  output logic                  out_peer_added,
  output logic                  out_peer_direct,
  output logic [1:0]            out_hello_request,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // User must change registers only between requests (unenforced); writes are taken
  assign cfg_ready = 1'b1;

  // Sequencer: take request, check header, then emit a drop, or scan, commit and emit
  mprf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Header checks, duplicate ring, peer table and result registers
  mprf_datapath #(
    .SEEN_DEPTH (SEEN_DEPTH),
    .PEER_SLOTS (PEER_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_packet_len      (in_packet_len),
    .in_packet_type     (in_packet_type),
    .in_flag_byte       (in_flag_byte),
    .in_network_id      (in_network_id),
    .in_source_id       (in_source_id),
    .in_dest_id         (in_dest_id),
    .in_seq_number      (in_seq_number),
    .in_ttl_byte        (in_ttl_byte),
    .in_auth_ok         (in_auth_ok),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_deliver        (out_deliver),
    .out_relay          (out_relay),
    .out_relay_ttl_byte (out_relay_ttl_byte),
    .out_peer_known     (out_peer_known),
    .out_peer_slot      (out_peer_slot),
    .out_peer_added     (out_peer_added),
    .out_peer_direct    (out_peer_direct),
    .out_hello_request  (out_hello_request)
  );

endmodule

/* rtl/core/mprf_checker.sv */
`timescale 1ns / 1ps

module mprf_checker import mprf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [2:0]            out_verdict,
  input logic                  out_deliver,
  input logic                  out_relay,
  input logic [7:0]            out_relay_ttl_byte,
  input logic                  out_peer_known,
  input logic                  out_peer_added,
  input logic                  out_peer_direct,
  input logic [1:0]            out_hello_request
);

  // A taken request holds the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> busy)
    else $error("busy low after a request was taken");

  // Result strobes never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A dropped request carries nothing but its verdict
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict != VERDICT_ACCEPTED)) |->
      (!out_deliver && !out_relay && !out_peer_known && !out_peer_added
       && !out_peer_direct && (out_hello_request == HELLO_NONE)))
    else $error("dropped request with non-zero result fields");

  // A new peer is known and always asks for a hello
  a_added_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_peer_added) |->
      (out_peer_known && (out_hello_request != HELLO_NONE)))
    else $error("new peer without slot or hello");

  // A relayed copy always carries the relayed bit
  a_relay_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_relay) |-> out_relay_ttl_byte[7])
    else $error("relay without relayed bit");

endmodule

bind mesh_packet_rx_filter mprf_checker u_mprf_checker (.*);
